>>> rtl/ost_pkg.sv
// ----------------------------------------------------------------------------
// ost_pkg - shared types and constants for the orientation settle tracker
// Sample vector, pose codes, register map and reset values.
// ----------------------------------------------------------------------------
package ost_pkg;

  // window counter width and its compare width against the settle count
  localparam int COUNT_BITS = 8;
  localparam int CNT_CMP_W  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  // squared distance of two 16-bit vectors: 3 * 2^32 max
  localparam int DIST_W = 34;
  // squared 16-bit limit
  localparam int LIM_W  = 32;

  localparam logic [7:0] FRESH_MAX = 8'hFF;

  typedef enum logic [2:0] {
    POSE_UNKNOWN      = 3'd0,
    POSE_UP           = 3'd1,
    POSE_DOWN         = 3'd2,
    POSE_PORTRAIT0    = 3'd3,
    POSE_PORTRAIT180  = 3'd4,
    POSE_LANDSCAPE0   = 3'd5,
    POSE_LANDSCAPE180 = 3'd6
  } pose_t;

  typedef enum logic [2:0] {
    REG_AXIS_THRESHOLD = 3'd0,
    REG_MOTION_DELTA   = 3'd1,
    REG_QUIET_DELTA    = 3'd2,
    REG_MAGNITUDE_MIN  = 3'd3,
    REG_MAGNITUDE_MAX  = 3'd4,
    REG_SETTLE_COUNT   = 3'd5
  } reg_idx_t;

  localparam logic [15:0] AXIS_THRESHOLD_RST = 16'd11475;
  localparam logic [15:0] MOTION_DELTA_RST   = 16'd1639;
  localparam logic [15:0] QUIET_DELTA_RST    = 16'd820;
  localparam logic [15:0] MAGNITUDE_MIN_RST  = 16'd12295;
  localparam logic [15:0] MAGNITUDE_MAX_RST  = 16'd20492;
  localparam logic [7:0]  SETTLE_COUNT_RST   = 8'd10;

  localparam logic [LIM_W-1:0] MOTION_SQ_RST  = LIM_W'(1639 * 1639);
  localparam logic [LIM_W-1:0] QUIET_SQ_RST   = LIM_W'(820 * 820);
  localparam logic [LIM_W-1:0] MAG_MIN_SQ_RST = LIM_W'(12295 * 12295);
  localparam logic [LIM_W-1:0] MAG_MAX_SQ_RST = LIM_W'(20492 * 20492);

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec_t;

  // classifier verdict on one sample
  typedef struct packed {
    pose_t pose;
    logic  quiet;
  } sample_info_t;

  // one result item
  typedef struct packed {
    pose_t      observed;
    pose_t      settled;
    logic       moving;
    logic [7:0] stable_count;
  } result_t;

endpackage

>>> rtl/orientation_settle_tracker.sv
// ----------------------------------------------------------------------------
// orientation_settle_tracker - accelerometer pose classifier and settle tracker
// A sample is held in the input register and its result is then offered
//   from the result register.
// Throughput: one sample per cycle while out_tready stays high; a stalled
//   result holds the input register, so each stall cycle blocks one input.
// Reset: synchronous active-low rst_n clears poses, counters, motion and
//   reference flags, both pipeline valids, and restores the config defaults.
// ----------------------------------------------------------------------------
module orientation_settle_tracker (
  input  logic        clk,
  input  logic        rst_n,

  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  input  logic [0:0]  in_tuser,   // [0] shake_active

  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] observed_pose, [5:3] settled_pose,
                                  // [13:6] stable_count, [15:14] zero
  output logic [0:0]  out_tuser,  // [0] moving

  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ost_pkg::*;

  // --------------------------------------------------------------------------
  // Config registers. Squared limits are kept alongside so the datapath
  // never squares a register in the sample path; they are registered from
  // the config values and trail a write, which the idle-only write rule covers.
  // --------------------------------------------------------------------------
  logic [15:0]      axis_thr_r, motion_delta_r, quiet_delta_r;
  logic [15:0]      mag_min_r, mag_max_r;
  logic [7:0]       settle_r;
  logic [LIM_W-1:0] motion_sq_r, quiet_sq_r, mag_min_sq_r, mag_max_sq_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_thr_r     <= AXIS_THRESHOLD_RST;
      motion_delta_r <= MOTION_DELTA_RST;
      quiet_delta_r  <= QUIET_DELTA_RST;
      mag_min_r      <= MAGNITUDE_MIN_RST;
      mag_max_r      <= MAGNITUDE_MAX_RST;
      settle_r       <= SETTLE_COUNT_RST;
      motion_sq_r    <= MOTION_SQ_RST;
      quiet_sq_r     <= QUIET_SQ_RST;
      mag_min_sq_r   <= MAG_MIN_SQ_RST;
      mag_max_sq_r   <= MAG_MAX_SQ_RST;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_AXIS_THRESHOLD: axis_thr_r     <= cfg_pwdata[15:0];
          REG_MOTION_DELTA:   motion_delta_r <= cfg_pwdata[15:0];
          REG_QUIET_DELTA:    quiet_delta_r  <= cfg_pwdata[15:0];
          REG_MAGNITUDE_MIN:  mag_min_r      <= cfg_pwdata[15:0];
          REG_MAGNITUDE_MAX:  mag_max_r      <= cfg_pwdata[15:0];
          REG_SETTLE_COUNT:   settle_r       <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      motion_sq_r  <= LIM_W'(motion_delta_r) * LIM_W'(motion_delta_r);
      quiet_sq_r   <= LIM_W'(quiet_delta_r) * LIM_W'(quiet_delta_r);
      mag_min_sq_r <= LIM_W'(mag_min_r) * LIM_W'(mag_min_r);
      mag_max_sq_r <= LIM_W'(mag_max_r) * LIM_W'(mag_max_r);
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AXIS_THRESHOLD: cfg_prdata = {16'd0, axis_thr_r};
      REG_MOTION_DELTA:   cfg_prdata = {16'd0, motion_delta_r};
      REG_QUIET_DELTA:    cfg_prdata = {16'd0, quiet_delta_r};
      REG_MAGNITUDE_MIN:  cfg_prdata = {16'd0, mag_min_r};
      REG_MAGNITUDE_MAX:  cfg_prdata = {16'd0, mag_max_r};
      REG_SETTLE_COUNT:   cfg_prdata = {24'd0, settle_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register. It takes a new sample whenever it is empty or its
  // content moves on in the same cycle, so the stream runs one sample per
  // clock while the result side keeps up.
  // --------------------------------------------------------------------------
  logic  in_valid_r;
  vec_t  in_vec_r;
  logic  in_shake_r;
  logic  in_xfer;
  logic  step;
  logic  out_valid_r;
  result_t out_res_r;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_vec_r.x <= in_tdata[15:0];
      in_vec_r.y <= in_tdata[31:16];
      in_vec_r.z <= in_tdata[47:32];
      in_shake_r <= in_tuser[0];
    end
  end

  // --------------------------------------------------------------------------
  // Single pass: classify, then update the windows. Tracking state advances
  // only on the cycle a sample moves into the result register.
  // --------------------------------------------------------------------------
  sample_info_t info;
  result_t      res;

  ost_classify u_classify (
    .s              (in_vec_r),
    .axis_threshold (axis_thr_r),
    .mag_min_sq     (mag_min_sq_r),
    .mag_max_sq     (mag_max_sq_r),
    .info           (info)
  );

  ost_track u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .s              (in_vec_r),
    .shake          (in_shake_r),
    .info           (info),
    .quiet_sq       (quiet_sq_r),
    .motion_sq      (motion_sq_r),
    .settle_need    (settle_r),
    .res            (res)
  );

  // --------------------------------------------------------------------------
  // Result register: holds a finished result until the sink takes it.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.stable_count, out_res_r.settled,
                       out_res_r.observed};
  assign out_tuser  = out_res_r.moving;

endmodule

>>> rtl/ost_dist.sv
// ----------------------------------------------------------------------------
// ost_dist - squared euclidean distance of two 16-bit vectors
// Three parallel 17x17 squares and a three-input add.
// ----------------------------------------------------------------------------
module ost_dist (
  input  ost_pkg::vec_t                 a,
  input  ost_pkg::vec_t                 b,
  output logic [ost_pkg::DIST_W-1:0]    sq_out
);
  import ost_pkg::*;

  logic signed [16:0]       dx, dy, dz;
  logic signed [DIST_W-1:0] dxw, dyw, dzw;
  logic signed [DIST_W-1:0] px, py, pz;

  assign dx = $signed({a.x[15], a.x}) - $signed({b.x[15], b.x});
  assign dy = $signed({a.y[15], a.y}) - $signed({b.y[15], b.y});
  assign dz = $signed({a.z[15], a.z}) - $signed({b.z[15], b.z});

  assign dxw = DIST_W'(dx);
  assign dyw = DIST_W'(dy);
  assign dzw = DIST_W'(dz);

  assign px = dxw * dxw;
  assign py = dyw * dyw;
  assign pz = dzw * dzw;

  assign sq_out = unsigned'(px + py + pz);

endmodule

>>> rtl/ost_classify.sv
// ----------------------------------------------------------------------------
// ost_classify - pose classifier and quiet check
// Picks the dominant gravity axis and checks the magnitude window.
// ----------------------------------------------------------------------------
module ost_classify (
  input  ost_pkg::vec_t                s,
  input  logic [15:0]                  axis_threshold,
  input  logic [ost_pkg::LIM_W-1:0]    mag_min_sq,
  input  logic [ost_pkg::LIM_W-1:0]    mag_max_sq,
  output ost_pkg::sample_info_t        info
);
  import ost_pkg::*;

  logic [15:0]       ax, ay, az;
  logic [DIST_W-1:0] mag_sq;
  pose_t             pose;

  // |v| fits 16 bits unsigned, including -32768
  assign ax = s.x[15] ? 16'(-s.x) : 16'(s.x);
  assign ay = s.y[15] ? 16'(-s.y) : 16'(s.y);
  assign az = s.z[15] ? 16'(-s.z) : 16'(s.z);

  always_comb begin
    priority if (az >= axis_threshold && az > ax && az > ay) begin
      pose = s.z[15] ? POSE_DOWN : POSE_UP;
    end else if (ax >= axis_threshold && ax > ay) begin
      pose = s.x[15] ? POSE_PORTRAIT180 : POSE_PORTRAIT0;
    end else if (ay >= axis_threshold) begin
      pose = s.y[15] ? POSE_LANDSCAPE0 : POSE_LANDSCAPE180;
    end else begin
      pose = POSE_UNKNOWN;
    end
  end

  ost_dist u_mag (
    .a      (s),
    .b      ('0),
    .sq_out (mag_sq)
  );

  assign info.pose  = pose;
  assign info.quiet = (pose != POSE_UNKNOWN) &&
                      (mag_sq >= DIST_W'(mag_min_sq)) &&
                      (mag_sq <= DIST_W'(mag_max_sq));

endmodule

>>> rtl/ost_track.sv
// ----------------------------------------------------------------------------
// ost_track - quiet windows, settle commit and motion state
// Holds the tracking state and forms the result for the sample in flight.
// ----------------------------------------------------------------------------
module ost_track (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  ost_pkg::vec_t                s,
  input  logic                         shake,
  input  ost_pkg::sample_info_t        info,
  input  logic [ost_pkg::LIM_W-1:0]    quiet_sq,
  input  logic [ost_pkg::LIM_W-1:0]    motion_sq,
  input  logic [7:0]                   settle_need,
  output ost_pkg::result_t             res
);
  import ost_pkg::*;

  localparam logic [COUNT_BITS-1:0] WIN_MAX = {COUNT_BITS{1'b1}};

  pose_t                  committed_r, committed_nxt;
  pose_t                  win_pose_r, win_pose_nxt;
  pose_t                  fresh_pose_r, fresh_pose_nxt;
  vec_t                   ref_r, ref_nxt;
  vec_t                   win_anchor_r, win_anchor_nxt;
  vec_t                   fresh_anchor_r, fresh_anchor_nxt;
  logic [COUNT_BITS-1:0]  win_cnt_r, win_cnt_nxt;
  logic [7:0]             fresh_cnt_r, fresh_cnt_nxt;
  logic                   motion_r, motion_nxt;
  logic                   have_ref_r, have_ref_nxt;

  logic [DIST_W-1:0]      d_fresh, d_win, d_ref;
  logic                   far_fresh, far_win, left_ref;
  logic                   restart, bump;

  ost_dist u_dfresh (.a(s), .b(fresh_anchor_r), .sq_out(d_fresh));
  ost_dist u_dwin   (.a(s), .b(win_anchor_r),   .sq_out(d_win));
  ost_dist u_dref   (.a(s), .b(ref_r),          .sq_out(d_ref));

  assign far_fresh = d_fresh > DIST_W'(quiet_sq);
  assign far_win   = d_win   > DIST_W'(quiet_sq);
  assign left_ref  = (d_ref >= DIST_W'(motion_sq)) ||
                     (info.pose != committed_r) || !info.quiet;

  // fast quiet window
  always_comb begin
    fresh_pose_nxt   = fresh_pose_r;
    fresh_anchor_nxt = fresh_anchor_r;
    fresh_cnt_nxt    = fresh_cnt_r;
    priority if (shake || !info.quiet) begin
      fresh_pose_nxt   = POSE_UNKNOWN;
      fresh_anchor_nxt = s;
      fresh_cnt_nxt    = '0;
    end else if (info.pose != fresh_pose_r || far_fresh) begin
      fresh_pose_nxt   = info.pose;
      fresh_anchor_nxt = s;
      fresh_cnt_nxt    = 8'd1;
    end else begin
      if (fresh_cnt_r != FRESH_MAX) begin
        fresh_cnt_nxt  = fresh_cnt_r + 8'd1;
      end
    end
  end

  // settle window, motion and commit
  always_comb begin
    restart    = 1'b0;
    bump       = 1'b0;
    motion_nxt = motion_r;
    priority if (!have_ref_r) begin
      if (win_cnt_r == '0 || info.pose != win_pose_r || far_win) begin
        restart = 1'b1;
      end else begin
        bump = info.quiet;
      end
    end else if (!motion_r) begin
      if (left_ref) begin
        motion_nxt = 1'b1;
        restart    = 1'b1;
      end
    end else if (!info.quiet || info.pose != win_pose_r || far_win) begin
      restart = 1'b1;
    end else begin
      bump = 1'b1;
    end

    win_anchor_nxt = win_anchor_r;
    win_pose_nxt   = win_pose_r;
    win_cnt_nxt    = win_cnt_r;
    if (restart) begin
      win_anchor_nxt = s;
      win_pose_nxt   = info.quiet ? info.pose : POSE_UNKNOWN;
      win_cnt_nxt    = info.quiet ? COUNT_BITS'(1) : '0;
    end else if (bump && win_cnt_r != WIN_MAX) begin
      win_cnt_nxt    = win_cnt_r + COUNT_BITS'(1);
    end

    committed_nxt = committed_r;
    ref_nxt       = ref_r;
    have_ref_nxt  = have_ref_r;
    if ((!have_ref_r || motion_nxt) &&
        (CNT_CMP_W'(win_cnt_nxt) >= CNT_CMP_W'(settle_need))) begin
      committed_nxt = win_pose_nxt;
      ref_nxt       = s;
      have_ref_nxt  = 1'b1;
      motion_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r  <= POSE_UNKNOWN;
      win_pose_r   <= POSE_UNKNOWN;
      fresh_pose_r <= POSE_UNKNOWN;
      win_cnt_r    <= '0;
      fresh_cnt_r  <= '0;
      motion_r     <= 1'b0;
      have_ref_r   <= 1'b0;
    end else if (step) begin
      committed_r  <= committed_nxt;
      win_pose_r   <= win_pose_nxt;
      fresh_pose_r <= fresh_pose_nxt;
      win_cnt_r    <= win_cnt_nxt;
      fresh_cnt_r  <= fresh_cnt_nxt;
      motion_r     <= motion_nxt;
      have_ref_r   <= have_ref_nxt;
    end
  end

  // anchors are only read once the matching pose/count says they were loaded
  always_ff @(posedge clk) begin
    if (step) begin
      ref_r          <= ref_nxt;
      win_anchor_r   <= win_anchor_nxt;
      fresh_anchor_r <= fresh_anchor_nxt;
    end
  end

  assign res.observed     = info.pose;
  assign res.settled      = committed_nxt;
  assign res.moving       = motion_nxt;
  assign res.stable_count = fresh_cnt_nxt;

endmodule

>>> rtl/ost_checker.sv
// ----------------------------------------------------------------------------
// ost_checker - port-level checks for the orientation settle tracker
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module ost_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser))
    else $error("result changed while stalled");

  // with nothing waiting at the output the input side never blocks
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // pose codes stay within the six poses and unknown
  a_pose_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7 && out_tdata[5:3] != 3'd7)
    else $error("pose code out of range");

  // an unknown pose is never quiet, so the fast window is empty
  a_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd0 |-> out_tdata[13:6] == 8'd0)
    else $error("stable count nonzero on unknown pose");

endmodule

bind orientation_settle_tracker ost_checker u_ost_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
